/* design/rcsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared types and constants for the RESP command stream parser.
// ----------------------------------------------------------------------------
package rcsp_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int LENGTH_BITS = 32;
  localparam int ACC_BITS    = 33;

  localparam logic [ACC_BITS-1:0] ACC_CAP = {ACC_BITS{1'b1}};

  localparam logic [15:0] MAX_ELEMENTS_RESET    = 16'd1024;
  localparam logic [31:0] MAX_BULK_LENGTH_RESET = 32'd536870912;

  // register indexes on the config port
  localparam logic REG_MAX_ELEMENTS    = 1'b0;
  localparam logic REG_MAX_BULK_LENGTH = 1'b1;

  localparam logic [7:0] CHAR_STAR   = 8'h2a;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_ELEM_END = 2'd1;
  localparam logic [1:0] KIND_EMPTY    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [2:0] ERR_TYPE     = 3'd0;
  localparam logic [2:0] ERR_NUMBER   = 3'd1;
  localparam logic [2:0] ERR_NEGATIVE = 3'd2;
  localparam logic [2:0] ERR_CRLF     = 3'd3;
  localparam logic [2:0] ERR_LIMIT    = 3'd4;

  typedef enum logic [3:0] {
    PH_STAR     = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_DOLLAR   = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_DATA_CR  = 4'd7,
    PH_DATA_LF  = 4'd8
  } phase_t;

endpackage : rcsp_pkg
`default_nettype wire

/* design/resp_command_stream_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// resp_command_stream_parser
// Parses '*' count CRLF then count '$' length CRLF data CRLF elements, one
// stream byte per cycle while the result side takes its words, giving data
// bytes, element ends, empty commands and error codes.
// ----------------------------------------------------------------------------
// result: a result word is on the output register in the cycle after its byte
//   is accepted
// throughput: one byte per cycle; the single output register lets the next
//   byte in whenever it is empty or being drained in the same cycle
// reset: synchronous rst returns the parser to waiting for '*', clears the
//   number and counters and loads the limit registers with their defaults
module resp_command_stream_parser
  import rcsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request byte stream
  input  wire logic        stream_valid,
  output logic             stream_ready,
  input  wire logic [7:0]  stream_byte,
  // result stream
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [15:0]      element_index,
  output logic             null_element,
  output logic             command_done,
  output logic [2:0]       error_code,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  phase_t phase, phase_next;

  logic [15:0]         max_elements;
  logic [31:0]         max_bulk_length;
  logic [ACC_BITS-1:0] number_accumulator, number_accumulator_next;
  logic                number_negative, number_negative_next;
  logic                digit_seen, digit_seen_next;
  logic [15:0]         elements_left, elements_left_next;
  logic [31:0]         bytes_left, bytes_left_next;
  logic [15:0]         current_index, current_index_next;

  logic        take;
  logic        is_digit;
  logic        minus_ok;
  logic        cr_ok;
  logic        num_err;
  logic [ACC_BITS+3:0] acc_sum;
  logic [ACC_BITS-1:0] acc_digit;
  logic        neg_nonzero;
  logic        neg_one;
  logic        count_over;
  logic        len_over;
  logic        last_elem;

  logic        fail;
  logic [2:0]  fail_code;
  logic        emit;
  logic [1:0]  res_kind;
  logic [7:0]  res_data;
  logic [15:0] res_index;
  logic        res_null;
  logic        res_done;
  logic        elem_end;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_elements    <= MAX_ELEMENTS_RESET;
      max_bulk_length <= MAX_BULK_LENGTH_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MAX_ELEMENTS) begin
        max_elements <= pwdata[15:0];
      end else begin
        max_bulk_length <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_BULK_LENGTH) begin
      prdata = max_bulk_length;
    end else begin
      prdata = {16'd0, max_elements};
    end
  end

  // handshake
  assign stream_ready = !result_valid || result_ready;
  assign take         = stream_valid && stream_ready;

  // number text decode
  assign is_digit  = (stream_byte >= CHAR_ZERO) && (stream_byte <= CHAR_NINE);
  assign minus_ok  = (stream_byte == CHAR_MINUS) && !digit_seen && !number_negative;
  assign cr_ok     = (stream_byte == CHAR_CR) && digit_seen;
  assign num_err   = !is_digit && !minus_ok && !cr_ok;

  // acc * 10 + digit, saturating
  assign acc_sum   = {1'b0, number_accumulator, 3'b000} + {3'b000, number_accumulator, 1'b0}
                   + {{(ACC_BITS+0){1'b0}}, stream_byte[3:0]};
  assign acc_digit = (|acc_sum[ACC_BITS+3:ACC_BITS]) ? ACC_CAP : acc_sum[ACC_BITS-1:0];

  assign neg_nonzero = number_negative && (number_accumulator != '0);
  assign neg_one     = number_negative && (number_accumulator == ACC_BITS'(1));
  assign count_over  = (number_accumulator > {{(ACC_BITS-16){1'b0}}, max_elements})
                    || (|number_accumulator[ACC_BITS-1:COUNT_BITS]);
  assign len_over    = (number_accumulator > {{(ACC_BITS-32){1'b0}}, max_bulk_length})
                    || (|number_accumulator[ACC_BITS-1:LENGTH_BITS]);
  assign last_elem   = (elements_left[15:1] == 15'd0);

  // error decode
  always_comb begin
    fail      = 1'b0;
    fail_code = ERR_TYPE;
    unique case (phase)
      PH_STAR: begin
        fail = (stream_byte != CHAR_STAR);
      end
      PH_COUNT, PH_LEN: begin
        fail      = num_err;
        fail_code = ERR_NUMBER;
      end
      PH_COUNT_LF: begin
        if (stream_byte != CHAR_LF) begin
          fail      = 1'b1;
          fail_code = ERR_CRLF;
        end else if (neg_nonzero) begin
          fail      = 1'b1;
          fail_code = ERR_NEGATIVE;
        end else if (count_over) begin
          fail      = 1'b1;
          fail_code = ERR_LIMIT;
        end
      end
      PH_DOLLAR: begin
        fail = (stream_byte != CHAR_DOLLAR);
      end
      PH_LEN_LF: begin
        if (stream_byte != CHAR_LF) begin
          fail      = 1'b1;
          fail_code = ERR_CRLF;
        end else if (neg_one) begin
          fail = 1'b0;
        end else if (neg_nonzero) begin
          fail      = 1'b1;
          fail_code = ERR_NEGATIVE;
        end else if (len_over) begin
          fail      = 1'b1;
          fail_code = ERR_LIMIT;
        end
      end
      PH_DATA: begin
        fail = 1'b0;
      end
      PH_DATA_CR: begin
        fail      = (stream_byte != CHAR_CR);
        fail_code = ERR_CRLF;
      end
      PH_DATA_LF: begin
        fail      = (stream_byte != CHAR_LF);
        fail_code = ERR_CRLF;
      end
      default: begin
        fail = 1'b1;
      end
    endcase
  end

  // element end happens on a null length or on the data trailer LF
  assign elem_end = !fail && (((phase == PH_LEN_LF) && neg_one) || (phase == PH_DATA_LF));

  // next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      if (fail) begin
        phase_next = PH_STAR;
      end else begin
        unique case (phase)
          PH_STAR:     phase_next = PH_COUNT;
          PH_COUNT:    phase_next = cr_ok ? PH_COUNT_LF : PH_COUNT;
          PH_COUNT_LF: phase_next = (number_accumulator == '0) ? PH_STAR : PH_DOLLAR;
          PH_DOLLAR:   phase_next = PH_LEN;
          PH_LEN:      phase_next = cr_ok ? PH_LEN_LF : PH_LEN;
          PH_LEN_LF: begin
            if (neg_one) begin
              phase_next = last_elem ? PH_STAR : PH_DOLLAR;
            end else if (number_accumulator == '0) begin
              phase_next = PH_DATA_CR;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA:     phase_next = (bytes_left <= 32'd1) ? PH_DATA_CR : PH_DATA;
          PH_DATA_CR:  phase_next = PH_DATA_LF;
          PH_DATA_LF:  phase_next = last_elem ? PH_STAR : PH_DOLLAR;
          default:     phase_next = PH_STAR;
        endcase
      end
    end
  end

  // results and datapath next values
  always_comb begin
    emit      = 1'b0;
    res_kind  = KIND_DATA;
    res_data  = 8'd0;
    res_index = current_index;
    res_null  = 1'b0;
    res_done  = 1'b0;

    number_accumulator_next = number_accumulator;
    number_negative_next    = number_negative;
    digit_seen_next         = digit_seen;
    elements_left_next      = elements_left;
    bytes_left_next         = bytes_left;
    current_index_next      = current_index;

    if (take) begin
      // number only survives while its text is being read
      if (!fail && (phase == PH_COUNT || phase == PH_LEN)) begin
        if (is_digit) begin
          number_accumulator_next = acc_digit;
          digit_seen_next         = 1'b1;
        end else if (minus_ok) begin
          number_negative_next = 1'b1;
        end
      end else if (phase != PH_COUNT_LF && phase != PH_LEN_LF && !fail) begin
        number_accumulator_next = '0;
        number_negative_next    = 1'b0;
        digit_seen_next         = 1'b0;
      end else begin
        number_accumulator_next = '0;
        number_negative_next    = 1'b0;
        digit_seen_next         = 1'b0;
      end

      if (fail) begin
        emit               = 1'b1;
        res_kind           = KIND_ERROR;
        elements_left_next = '0;
        bytes_left_next    = '0;
        current_index_next = '0;
      end else if (elem_end) begin
        emit     = 1'b1;
        res_kind = KIND_ELEM_END;
        res_null = (phase == PH_LEN_LF);
        res_done = last_elem;
        if (last_elem) begin
          elements_left_next = '0;
          current_index_next = '0;
        end else begin
          elements_left_next = elements_left - 16'd1;
          current_index_next = current_index + 16'd1;
        end
      end else if (phase == PH_COUNT_LF) begin
        current_index_next = '0;
        if (number_accumulator == '0) begin
          emit      = 1'b1;
          res_kind  = KIND_EMPTY;
          res_index = '0;
        end else begin
          elements_left_next = number_accumulator[15:0];
        end
      end else if (phase == PH_LEN_LF) begin
        bytes_left_next = number_accumulator[31:0];
      end else if (phase == PH_DATA) begin
        emit     = 1'b1;
        res_kind = KIND_DATA;
        res_data = stream_byte;
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_STAR;
      number_accumulator <= '0;
      number_negative    <= 1'b0;
      digit_seen         <= 1'b0;
      elements_left      <= '0;
      bytes_left         <= '0;
      current_index      <= '0;
      result_valid       <= 1'b0;
    end else begin
      phase              <= phase_next;
      number_accumulator <= number_accumulator_next;
      number_negative    <= number_negative_next;
      digit_seen         <= digit_seen_next;
      elements_left      <= elements_left_next;
      bytes_left         <= bytes_left_next;
      current_index      <= current_index_next;
      if (take && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind          <= res_kind;
      data_byte     <= res_data;
      element_index <= res_index;
      null_element  <= res_null;
      command_done  <= res_done;
      error_code    <= (res_kind == KIND_ERROR) ? fail_code : ERR_TYPE;
    end
  end

  // checks
  a_fail_restarts: assert property (@(posedge clk) disable iff (rst)
    take && fail |=> phase == PH_STAR)
    else $error("parser did not restart after an error");

  a_star_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STAR |-> elements_left == '0 && current_index == '0)
    else $error("counters not clear while waiting for a command");

  a_data_pending: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != '0)
    else $error("data phase with no bytes left");

  a_done_on_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && command_done |-> kind == KIND_ELEM_END)
    else $error("command done on a word that is not an element end");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != KIND_DATA |-> data_byte == 8'd0)
    else $error("data byte set on a non-data word");

endmodule : resp_command_stream_parser
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives request bytes into the RESP command parser and checks every result
// word against a cycle-free parser model kept in step with accepted bytes.
// Directed commands cover framing, number forms, null and empty elements and
// the limit registers; random commands follow, some of them corrupted.
// ----------------------------------------------------------------------------
module tb_top;
  import rcsp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic        nul;
    logic        done;
    logic [2:0]  err;
  } parse_word_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        stream_valid = 1'b0;
  logic [7:0]  stream_byte  = '0;
  logic        result_ready = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;

  logic        stream_ready;
  logic        result_valid;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] element_index;
  logic        null_element;
  logic        command_done;
  logic [2:0]  error_code;
  logic [31:0] prdata;
  logic        pready;

  resp_command_stream_parser i_dut (.*);

  always #5 clk = ~clk;

  // parser model state
  phase_t              ph         = PH_STAR;
  logic [ACC_BITS-1:0] acc        = '0;
  bit                  neg        = 1'b0;
  bit                  dig        = 1'b0;
  logic [15:0]         elems_left = '0;
  logic [31:0]         bytes_left = '0;
  logic [15:0]         cur_idx    = '0;
  logic [15:0]         lim_elems  = MAX_ELEMENTS_RESET;
  logic [31:0]         lim_len    = MAX_BULK_LENGTH_RESET;

  parse_word_t expected_words[$];
  logic [7:0]  pending_bytes[$];

  int fail_count    = 0;
  int words_checked = 0;
  int bytes_sent    = 0;
  int errors_seen   = 0;
  int ready_hold    = 0;
  bit idle_on       = 1'b1;

  function automatic void emit(input logic [1:0] k, input logic [7:0] d,
                               input logic [15:0] idx, input logic nl,
                               input logic dn, input logic [2:0] e);
    parse_word_t w;
    w.kind  = k;
    w.data  = d;
    w.index = idx;
    w.nul   = nl;
    w.done  = dn;
    w.err   = e;
    if (k == KIND_ERROR) errors_seen++;
    expected_words = {expected_words, w};
  endfunction

  function automatic void clear_num();
    acc = '0;
    neg = 1'b0;
    dig = 1'b0;
  endfunction

  function automatic void reject(input logic [2:0] code);
    emit(KIND_ERROR, 8'd0, cur_idx, 1'b0, 1'b0, code);
    ph = PH_STAR;
    clear_num();
    elems_left = '0;
    bytes_left = '0;
    cur_idx    = '0;
  endfunction

  function automatic void close_element(input logic nl);
    logic last;
    last = (elems_left <= 16'd1);
    emit(KIND_ELEM_END, 8'd0, cur_idx, nl, last, ERR_TYPE);
    if (last) begin
      elems_left = '0;
      cur_idx    = '0;
      ph         = PH_STAR;
    end else begin
      elems_left = elems_left - 16'd1;
      cur_idx    = cur_idx + 16'd1;
      ph         = PH_DOLLAR;
    end
  endfunction

  // one byte of a decimal number; returns 1 when the byte breaks the number
  function automatic bit num_char(input logic [7:0] b, input phase_t nxt);
    logic [63:0] t;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      t   = {31'd0, acc} * 64'd10 + {56'd0, b - CHAR_ZERO};
      acc = (t > {31'd0, ACC_CAP}) ? ACC_CAP : t[ACC_BITS-1:0];
      dig = 1'b1;
      return 1'b0;
    end
    if (b == CHAR_MINUS && !dig && !neg) begin
      neg = 1'b1;
      return 1'b0;
    end
    if (b == CHAR_CR && dig) begin
      ph = nxt;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void track_byte(input logic [7:0] b);
    case (ph)
      PH_STAR: begin
        if (b != CHAR_STAR) reject(ERR_TYPE);
        else begin
          clear_num();
          ph = PH_COUNT;
        end
      end
      PH_COUNT: if (num_char(b, PH_COUNT_LF)) reject(ERR_NUMBER);
      PH_COUNT_LF: begin
        if (b != CHAR_LF) reject(ERR_CRLF);
        else if (neg && acc != 0) reject(ERR_NEGATIVE);
        else if (acc > {17'd0, lim_elems} || (acc >> COUNT_BITS) != 0) reject(ERR_LIMIT);
        else if (acc == 0) begin
          clear_num();
          cur_idx = '0;
          emit(KIND_EMPTY, 8'd0, 16'd0, 1'b0, 1'b0, ERR_TYPE);
          ph = PH_STAR;
        end else begin
          elems_left = acc[15:0];
          clear_num();
          cur_idx = '0;
          ph      = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (b != CHAR_DOLLAR) reject(ERR_TYPE);
        else begin
          clear_num();
          ph = PH_LEN;
        end
      end
      PH_LEN: if (num_char(b, PH_LEN_LF)) reject(ERR_NUMBER);
      PH_LEN_LF: begin
        if (b != CHAR_LF) reject(ERR_CRLF);
        else if (neg && acc == 1) begin
          clear_num();
          close_element(1'b1);
        end else if (neg && acc != 0) reject(ERR_NEGATIVE);
        else if (acc > {1'b0, lim_len} || (acc >> LENGTH_BITS) != 0) reject(ERR_LIMIT);
        else begin
          bytes_left = acc[31:0];
          ph = (acc == 0) ? PH_DATA_CR : PH_DATA;
          clear_num();
        end
      end
      PH_DATA: begin
        emit(KIND_DATA, b, cur_idx, 1'b0, 1'b0, ERR_TYPE);
        if (bytes_left != 0) bytes_left = bytes_left - 32'd1;
        if (bytes_left == 0) ph = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (b != CHAR_CR) reject(ERR_CRLF);
        else ph = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (b != CHAR_LF) reject(ERR_CRLF);
        else close_element(1'b0);
      end
      default: reject(ERR_TYPE);
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
  endfunction

  // '|' stands for CR LF, '^' for a lone CR
  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == "|") begin
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
      end else if (s[i] == "^") begin
        add_byte(CHAR_CR);
      end else begin
        add_byte(s[i]);
      end
    end
  endfunction

  function automatic void push_number(input longint unsigned mag, input bit minus);
    string s;
    s = $sformatf("%0d", mag);
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    if (minus) s = {"-", s};
    push_text(s);
  endfunction

  // result side: random stall bursts while idling is on
  always @(posedge clk) begin
    if (ready_hold > 0) ready_hold = ready_hold - 1;
    else if (idle_on && $urandom_range(0, 7) == 0) ready_hold = $urandom_range(1, 9);
    result_ready <= (ready_hold == 0);
  end

  always @(posedge clk) begin : check_words
    parse_word_t w;
    if (!rst && result_valid && result_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, kind %0d", $time, kind);
        fail_count++;
      end else begin
        w = expected_words.pop_front();
        check_field("kind", w.kind, kind);
        check_field("data_byte", w.data, data_byte);
        check_field("element_index", w.index, element_index);
        check_field("null_element", w.nul, null_element);
        check_field("command_done", w.done, command_done);
        check_field("error_code", w.err, error_code);
        words_checked++;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      stream_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    stream_valid <= 1'b1;
    stream_byte  <= b;
    @(posedge clk);
    while (!stream_ready) @(posedge clk);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_pending();
    while (pending_bytes.size() != 0) send_byte(pending_bytes.pop_front());
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_pending();
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic [2:0] addr, output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    value = prdata;
  endtask

  // limits change only with the parser drained
  task automatic set_limits(input logic [15:0] el, input logic [31:0] len);
    logic [31:0] rd;
    stream_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    reg_write({REG_MAX_ELEMENTS, 2'b00}, {16'd0, el});
    reg_write({REG_MAX_BULK_LENGTH, 2'b00}, len);
    lim_elems = el;
    lim_len   = len;
    reg_read({REG_MAX_ELEMENTS, 2'b00}, rd);
    check_field("max_elements readback", {16'd0, el}, rd);
    reg_read({REG_MAX_BULK_LENGTH, 2'b00}, rd);
    check_field("max_bulk_length readback", len, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_basic_command();
    push_text("*1|$3|");
    add_byte(8'h00);
    add_byte(8'hff);
    send_text("a|");
  endtask

  task automatic test_framing_errors();
    send_text("x");
    send_byte(8'hff);
    send_text("*1|#");
    send_text("*1^x");
    send_text("*1|$1|ab");
    send_text("*1|$1|a^z");
  endtask

  task automatic test_number_forms();
    send_text("*-0|*00|");
    send_text("*--*1-*^");
    send_text("*-2|*-99999999999|");
    send_text("*1|$99999999999|");
    send_text("*1|$-3|");
    send_text("*01|$-1|");
  endtask

  task automatic test_null_and_empty();
    send_text("*0|");
    send_text("*3|$-1|$0||$1|z|");
  endtask

  task automatic test_limits();
    set_limits(16'd0, 32'd0);
    send_text("*0|*1|");
    set_limits(16'd1, 32'd0);
    send_text("*1|$0||*1|$1|");
    set_limits(16'hffff, 32'hffff_ffff);
    send_text("*65535|x*65536|*1|$4294967296|");
    set_limits(MAX_ELEMENTS_RESET, MAX_BULK_LENGTH_RESET);
    send_text("*1025|*1024|x*1|$2|ok|");
  endtask

  // mostly well-formed commands with random content, some noise and damage
  task automatic build_command();
    int r;
    int cnt;
    int len;
    int pos;
    logic [7:0] syntax_chars[6];
    syntax_chars = '{CHAR_CR, CHAR_LF, CHAR_MINUS, CHAR_DOLLAR, CHAR_STAR, CHAR_ZERO};
    r = $urandom_range(0, 99);
    if (r < 6) begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      push_text("*");
      if (r < 9) begin
        push_number($urandom_range(1, 3), 1'b1);
        cnt = 0;
      end else begin
        push_number(cnt, (cnt == 0) && $urandom_range(0, 1));
      end
      push_text("|");
      repeat (cnt) begin
        if ($urandom_range(0, 15) == 0) begin
          push_text("$-1|");
        end else begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          push_text("$");
          push_number(len, 1'b0);
          push_text("|");
          repeat (len) add_byte(8'($urandom_range(0, 255)));
          push_text("|");
        end
      end
      if ($urandom_range(0, 99) < 15) begin
        pos = $urandom_range(0, pending_bytes.size() - 1);
        case ($urandom_range(0, 2))
          0: pending_bytes[pos] = $urandom_range(0, 255);
          1: pending_bytes[pos] = syntax_chars[$urandom_range(0, 5)];
          default: begin
            // cut the command short
            while (pending_bytes.size() > pos) void'(pending_bytes.pop_back());
          end
        endcase
      end
    end
  endtask

  task automatic test_random_traffic(input int n_bytes, input bit with_idle);
    int stop_at;
    idle_on = with_idle;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_command();
      send_pending();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_basic_command();
    test_framing_errors();
    test_number_forms();
    test_null_and_empty();
    test_limits();
    set_limits($urandom_range(1, 4), $urandom_range(4, 12));
    test_random_traffic(130, 1'b1);
    set_limits(16'hffff, 32'hffff_ffff);
    test_random_traffic(130, 1'b1);
    set_limits(16'd2, 32'd0);
    test_random_traffic(60, 1'b1);
    set_limits(16'd3, $urandom_range(6, 40));
    test_random_traffic(180, 1'b0);
    stream_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("sent %0d stream bytes through directed and random commands", bytes_sent);
    $display("checked %0d result words, %0d of them parse errors", words_checked,
             errors_seen);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
